// ----- src/bnaf_pkg.sv -----
// ----------------------------------------------------------------------------
// bnaf_pkg
// Shared constants, types and the network update function of the attractor
// finder.
// ----------------------------------------------------------------------------
package bnaf_pkg;

  localparam int NODES       = 5;
  localparam int STATE_W     = NODES;
  localparam int STATE_CNT   = 1 << NODES;
  localparam int STEPS_W     = $clog2(STATE_CNT + 1);
  localparam int STEPS_DEPTH = STATE_CNT + 1;
  localparam int CNT_W       = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  // last iteration index of either loop
  localparam logic [STEPS_W-1:0] LAST_ITER = STEPS_W'(STATE_CNT - 1);

  typedef logic [STATE_W-1:0] state_t;
  typedef logic [STEPS_W-1:0] steps_t;
  typedef logic [CNT_W-1:0]   count_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic meet_en;
    logic period_en;
    logic rd_en;
    logic wr_en;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic meet_done;
    logic period_done;
  } status_t;

  // one synchronous update of the fixed network
  function automatic state_t net_update(input state_t s);
    state_t n;
    n[0] = (s[0] | s[1]) & ~s[4] & ~s[2];
    n[1] = s[3] & ~s[0];
    n[2] = s[0] & ~s[3];
    n[3] = s[0] & s[4] & ~s[1] & ~s[3];
    n[4] = s[0] & ~s[4] & ~s[2];
    return n;
  endfunction

  // saturating increment
  function automatic count_t bump(input count_t c);
    return (c == CNT_MAX) ? c : c + count_t'(1);
  endfunction

endpackage

// ----- src/boolean_network_attractor_finder_core.sv -----
// ----------------------------------------------------------------------------
// boolean_network_attractor_finder_core
// Floyd cycle detection on a fixed 5-node Boolean network, with saturating
// histograms of attractor state, meeting step count and period.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-----------------
//   in      | in_start_state                          | in_valid/in_ready
//   out     | out_attractor_state, out_meet_steps,    | out_valid/out_ready
//           | out_period_minus_one, out_*_count       |
//
// Each request runs M meeting (1..32) and P period iterations (1..32) of the
// update functions, then the histogram read, write-back and result load.
// Synchronous active-low reset clears the controller and the histogram valid
// bits, so all counts read as zero after reset with no clearing pass.
// A new request is taken while a result waits in the output register; a
// stalled output holds the next result in its final state.
// ----------------------------------------------------------------------------
module boolean_network_attractor_finder_core
  import bnaf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  state_t in_start_state,
  output logic   out_valid,
  input  logic   out_ready,
  output state_t out_attractor_state,
  output steps_t out_meet_steps,
  output state_t out_period_minus_one,
  output count_t out_attractor_count,
  output count_t out_meet_steps_count,
  output count_t out_period_count
);

  cmd_t    cmd;
  status_t status;

  bnaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bnaf_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_start_state       (in_start_state),
    .out_attractor_state  (out_attractor_state),
    .out_meet_steps       (out_meet_steps),
    .out_period_minus_one (out_period_minus_one),
    .out_attractor_count  (out_attractor_count),
    .out_meet_steps_count (out_meet_steps_count),
    .out_period_count     (out_period_count)
  );

endmodule

// ----- src/bnaf_ram.sv -----
// ----------------------------------------------------------------------------
// bnaf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bnaf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/bnaf_dp.sv -----
// ----------------------------------------------------------------------------
// bnaf_dp
// Datapath: tortoise and hare registers, step and period counters, the three
// histogram RAMs with their valid bits, and the result registers.
// ----------------------------------------------------------------------------
module bnaf_dp
  import bnaf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    cmd,
  output status_t status,
  input  state_t  in_start_state,
  output state_t  out_attractor_state,
  output steps_t  out_meet_steps,
  output state_t  out_period_minus_one,
  output count_t  out_attractor_count,
  output count_t  out_meet_steps_count,
  output count_t  out_period_count
);

  state_t start_r, slow_r, fast_r;
  steps_t steps_r, period_r;

  state_t slow_step, fast_step1, fast_step2;
  steps_t steps_fix;
  state_t pm1;

  logic [STATE_CNT-1:0]   att_vld_r;
  logic [STEPS_DEPTH-1:0] stp_vld_r;
  logic [STATE_CNT-1:0]   per_vld_r;

  count_t att_rd, stp_rd, per_rd;
  count_t att_new, stp_new, per_new;
  count_t att_cnt_r, stp_cnt_r, per_cnt_r;

  state_t out_att_r, out_pm1_r;
  steps_t out_steps_r;
  count_t out_att_cnt_r, out_stp_cnt_r, out_per_cnt_r;

  assign slow_step  = net_update(slow_r);
  assign fast_step1 = net_update(fast_r);
  assign fast_step2 = net_update(fast_step1);

  // meeting at the start state counts as no transient
  assign steps_fix = (slow_r == start_r) ? '0 : steps_r;
  assign pm1       = period_r[STATE_W-1:0] - state_t'(1);

  assign status.meet_done   = (slow_step == fast_step2) || (steps_r == LAST_ITER);
  assign status.period_done = (fast_step1 == slow_r) || (period_r == LAST_ITER);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r  <= in_start_state;
      slow_r   <= in_start_state;
      fast_r   <= in_start_state;
      steps_r  <= '0;
      period_r <= '0;
    end else if (cmd.meet_en) begin
      slow_r  <= slow_step;
      fast_r  <= fast_step2;
      steps_r <= steps_r + steps_t'(1);
    end else if (cmd.period_en) begin
      fast_r   <= fast_step1;
      period_r <= period_r + steps_t'(1);
    end
  end

  bnaf_ram #(.WIDTH(CNT_W), .DEPTH(STATE_CNT)) u_att_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (slow_r),
    .wdata (att_new),
    .re    (cmd.rd_en),
    .raddr (slow_r),
    .rdata (att_rd)
  );

  bnaf_ram #(.WIDTH(CNT_W), .DEPTH(STEPS_DEPTH)) u_stp_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (steps_fix),
    .wdata (stp_new),
    .re    (cmd.rd_en),
    .raddr (steps_fix),
    .rdata (stp_rd)
  );

  bnaf_ram #(.WIDTH(CNT_W), .DEPTH(STATE_CNT)) u_per_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (pm1),
    .wdata (per_new),
    .re    (cmd.rd_en),
    .raddr (pm1),
    .rdata (per_rd)
  );

  // an entry never written reads as zero
  assign att_new = bump(att_vld_r[slow_r]    ? att_rd : '0);
  assign stp_new = bump(stp_vld_r[steps_fix] ? stp_rd : '0);
  assign per_new = bump(per_vld_r[pm1]       ? per_rd : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_vld_r <= '0;
      stp_vld_r <= '0;
      per_vld_r <= '0;
    end else if (cmd.wr_en) begin
      att_vld_r[slow_r]    <= 1'b1;
      stp_vld_r[steps_fix] <= 1'b1;
      per_vld_r[pm1]       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      att_cnt_r <= att_new;
      stp_cnt_r <= stp_new;
      per_cnt_r <= per_new;
    end
    if (cmd.out_load) begin
      out_att_r     <= slow_r;
      out_steps_r   <= steps_fix;
      out_pm1_r     <= pm1;
      out_att_cnt_r <= att_cnt_r;
      out_stp_cnt_r <= stp_cnt_r;
      out_per_cnt_r <= per_cnt_r;
    end
  end

  assign out_attractor_state  = out_att_r;
  assign out_meet_steps       = out_steps_r;
  assign out_period_minus_one = out_pm1_r;
  assign out_attractor_count  = out_att_cnt_r;
  assign out_meet_steps_count = out_stp_cnt_r;
  assign out_period_count     = out_per_cnt_r;

endmodule

// ----- src/bnaf_ctrl.sv -----
// ----------------------------------------------------------------------------
// bnaf_ctrl
// Controller: sequences load, meeting loop, period loop, histogram
// read-modify-write and result hand-off.
// ----------------------------------------------------------------------------
module bnaf_ctrl
  import bnaf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MEET   = 6'b000010,
    S_PERIOD = 6'b000100,
    S_READ   = 6'b001000,
    S_UPDATE = 6'b010000,
    S_DONE   = 6'b100000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MEET;
        end
      end
      S_MEET: begin
        cmd.meet_en = 1'b1;
        if (status.meet_done) begin
          state_nxt = S_PERIOD;
        end
      end
      S_PERIOD: begin
        cmd.period_en = 1'b1;
        if (status.period_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.wr_en = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_meet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_MEET))
    else $error("load did not start the meeting loop");

  a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> cmd.wr_en)
    else $error("histogram read not followed by write-back");

  a_meet_to_period: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.meet_en && status.meet_done) |=> cmd.period_en)
    else $error("period loop did not follow meeting");

  a_out_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load did not raise out_valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

endmodule

// ----- dv/attractor_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attractor_result_checker
// Watches both channels of the attractor finder. Every accepted request is
// traced through the network here (tortoise/hare meeting, then the cycle
// length), the three saturating histograms are bumped, and the resulting
// record is queued. Every accepted result is compared field by field with the
// oldest queued record.
// ----------------------------------------------------------------------------
module attractor_result_checker
  import bnaf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_ready,
  input  state_t in_start_state,
  input  logic   out_valid,
  input  logic   out_ready,
  input  state_t out_attractor_state,
  input  steps_t out_meet_steps,
  input  state_t out_period_minus_one,
  input  count_t out_attractor_count,
  input  count_t out_meet_steps_count,
  input  count_t out_period_count,
  input  logic   run_end,
  output int     error_count,
  output int     pending
);

  typedef struct packed {
    state_t attractor;
    steps_t steps;
    state_t period;
    count_t attractor_cnt;
    count_t steps_cnt;
    count_t period_cnt;
  } attractor_result_t;

  count_t attractor_tally [STATE_CNT];
  count_t steps_tally     [STEPS_DEPTH];
  count_t period_tally    [STATE_CNT];

  attractor_result_t expected_attractors[$];
  attractor_result_t want;
  int                fail_total;

  // one synchronous update of all five nodes
  function automatic state_t network_step(input state_t cur);
    logic a0, a1, a2, a3, a4;
    state_t nxt;
    {a4, a3, a2, a1, a0} = cur;
    nxt = '0;
    nxt[0] = (a0 || a1) && !a4 && !a2;
    nxt[1] = a3 && !a0;
    nxt[2] = a0 && !a3;
    nxt[3] = a0 && a4 && !a1 && !a3;
    nxt[4] = a0 && !a4 && !a2;
    return nxt;
  endfunction

  function automatic count_t tally_bump(input count_t c);
    if (c != CNT_MAX)
      c = c + 16'd1;
    return c;
  endfunction

  function automatic attractor_result_t trace_attractor(input state_t start);
    attractor_result_t r;
    state_t slow, fast;
    int     iters, lap;
    slow  = start;
    fast  = start;
    iters = 0;
    do begin
      slow  = network_step(slow);
      fast  = network_step(network_step(fast));
      iters = iters + 1;
    end while (slow != fast && iters < STATE_CNT);
    // meeting back at the start counts as no transient
    if (slow == start)
      iters = 0;
    lap = 0;
    do begin
      fast = network_step(fast);
      lap  = lap + 1;
    end while (fast != slow && lap < STATE_CNT);
    r.attractor = slow;
    r.steps     = steps_t'(iters);
    r.period    = state_t'(lap - 1);
    attractor_tally[r.attractor] = tally_bump(attractor_tally[r.attractor]);
    steps_tally[r.steps]         = tally_bump(steps_tally[r.steps]);
    period_tally[r.period]       = tally_bump(period_tally[r.period]);
    r.attractor_cnt = attractor_tally[r.attractor];
    r.steps_cnt     = steps_tally[r.steps];
    r.period_cnt    = period_tally[r.period];
    return r;
  endfunction

  task automatic check_field(input string field, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_val,
               act_val);
      fail_total = fail_total + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (attractor_tally[i]) attractor_tally[i] = '0;
      foreach (steps_tally[i])     steps_tally[i]     = '0;
      foreach (period_tally[i])    period_tally[i]    = '0;
      expected_attractors.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_attractors.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual attractor %0d", $time,
                   out_attractor_state);
          fail_total = fail_total + 1;
        end else begin
          want = expected_attractors.pop_front();
          check_field("attractor_state", want.attractor, out_attractor_state);
          check_field("meet_steps", want.steps, out_meet_steps);
          check_field("period_minus_one", want.period, out_period_minus_one);
          check_field("attractor_count", want.attractor_cnt, out_attractor_count);
          check_field("meet_steps_count", want.steps_cnt, out_meet_steps_count);
          check_field("period_count", want.period_cnt, out_period_count);
        end
      end
      if (in_valid && in_ready)
        expected_attractors.push_back(trace_attractor(in_start_state));
      if (run_end && expected_attractors.size() != 0) begin
        $display("%0t: missing results: expected %0d more, actual 0", $time,
                 expected_attractors.size());
        fail_total = fail_total + expected_attractors.size();
        expected_attractors.delete();
      end
      pending <= expected_attractors.size();
    end
    error_count <= fail_total;
  end

endmodule

// ----- dv/boolean_network_attractor_finder_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boolean_network_attractor_finder_core_tb
// Drives start states into the attractor finder: a directed set of corner
// states, then random phases with varying request gaps and result stalls,
// draining all results after each. The checker beside the block predicts and
// compares.
// ----------------------------------------------------------------------------
module boolean_network_attractor_finder_core_tb;
  import bnaf_pkg::*;

  localparam int PHASE_REQUESTS = 266;
  localparam int DRAIN_CYCLES   = 80;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  state_t in_start_state = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  state_t out_attractor_state;
  steps_t out_meet_steps;
  state_t out_period_minus_one;
  count_t out_attractor_count;
  count_t out_meet_steps_count;
  count_t out_period_count;
  logic   run_end = 1'b0;
  int     error_count;
  int     pending;

  int idle_pct  = 0;
  int stall_pct = 0;

  always #6 clk = ~clk;

  boolean_network_attractor_finder_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_start_state       (in_start_state),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_attractor_state  (out_attractor_state),
    .out_meet_steps       (out_meet_steps),
    .out_period_minus_one (out_period_minus_one),
    .out_attractor_count  (out_attractor_count),
    .out_meet_steps_count (out_meet_steps_count),
    .out_period_count     (out_period_count)
  );

  attractor_result_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_start_state       (in_start_state),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_attractor_state  (out_attractor_state),
    .out_meet_steps       (out_meet_steps),
    .out_period_minus_one (out_period_minus_one),
    .out_attractor_count  (out_attractor_count),
    .out_meet_steps_count (out_meet_steps_count),
    .out_period_count     (out_period_count),
    .run_end              (run_end),
    .error_count          (error_count),
    .pending              (pending)
  );

  always @(posedge clk)
    out_ready <= ($urandom_range(0, 99) >= stall_pct);

  task automatic send_start_state(input state_t s);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid       <= 1'b0;
      in_start_state <= state_t'($urandom);
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_start_state <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and hold until every queued result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    state_t corner_states[20];
    int     phase_idle[5];
    int     phase_stall[5];
    corner_states = '{5'd0, 5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd30, 5'd29, 5'd27,
                      5'd23, 5'd15, 5'd3, 5'd5, 5'd9, 5'd17, 5'd24, 5'd12, 5'd0, 5'd31};
    phase_idle  = '{0, 78, 0, 25, 0};
    phase_stall = '{0, 0, 78, 25, 0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_states[i])
      send_start_state(corner_states[i]);
    wait_results_drained();

    foreach (phase_idle[p]) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      repeat (PHASE_REQUESTS)
        send_start_state(state_t'($urandom_range(0, STATE_CNT - 1)));
      wait_results_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    run_end <= 1'b1;
    repeat (2) @(posedge clk);
    if (error_count == 0)
      $display("boolean_network_attractor_finder_core_tb: done, clean");
    else
      $display("boolean_network_attractor_finder_core_tb: done, errors");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("boolean_network_attractor_finder_core_tb: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/bnaf_pkg.sv
src/bnaf_ram.sv
src/bnaf_dp.sv
src/bnaf_ctrl.sv
src/boolean_network_attractor_finder_core.sv
dv/attractor_result_checker.sv
dv/boolean_network_attractor_finder_core_tb.sv
